[rtl/core/sbsm_pkg.sv]
// sbsm_pkg: shared types, constants and helpers of the serial bank switch mapper
// no dependencies; used by the channel interfaces, sbsm_update and the top level
package sbsm_pkg;

	localparam int ADDR_W   = 16;
	localparam int DATA_W   = 8;
	localparam int SLOT_W   = 7;
	localparam int CHR_W    = 7;
	localparam int COUNT_W  = 8;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	// control register indexes, taken from address bits 14:13
	localparam logic [1:0] REG_CTRL = 2'd0;
	localparam logic [1:0] REG_CHR0 = 2'd1;
	localparam logic [1:0] REG_CHR1 = 2'd2;
	localparam logic [1:0] REG_PRG  = 2'd3;

	// config register indexes
	localparam logic CFG_BANK_COUNT = 1'b0;
	localparam logic CFG_HAS_CHR    = 1'b1;

	localparam logic [2:0] NO_LOAD       = 3'd4;
	localparam logic [2:0] LAST_BIT      = 3'd4;
	localparam logic [4:0] CTRL0_RESET   = 5'h0C;
	localparam logic [7:0] COUNT_RESET   = 8'd32;
	localparam logic [7:0] BIG_COUNT     = 8'd128;
	localparam logic [7:0] MID_COUNT     = 8'd64;
	localparam logic [4:0] HI_ONE_LARGE  = 5'd30;
	localparam logic [4:0] HI_TWO_LARGE  = 5'd31;

	typedef struct packed {
		logic [4:0]      shift_bits;
		logic [2:0]      shift_count;
		logic [1:0]      last_region;
		logic [3:0][4:0] ctrl;
		logic [3:0][4:0] slots;       // only the low five bits reach the outputs
		logic [1:0]      outer_base;
		logic            swap_latch;
		logic [6:0]      chr_low;
		logic [6:0]      chr_high;
	} map_state_t;

	typedef struct packed {
		logic [7:0] bank_count;
		logic       has_chr_rom;
	} map_cfg_t;

	function automatic logic is_small(input logic [7:0] count);
		return (count != BIG_COUNT) && (count != MID_COUNT);
	endfunction

	function automatic logic [4:0] hi_one(input logic [7:0] count);
		logic [7:0] v;
		v = count - 8'd2;
		return is_small(count) ? v[4:0] : HI_ONE_LARGE;
	endfunction

	function automatic logic [4:0] hi_two(input logic [7:0] count);
		logic [7:0] v;
		v = count - 8'd1;
		return is_small(count) ? v[4:0] : HI_TWO_LARGE;
	endfunction

	// two-write latch on 1024K carts: {swap_latch, outer_base}
	function automatic logic [2:0] swap_step(input logic swap, input logic [1:0] outer,
			input logic b1, input logic b2, input logic use2);
		if (swap)
			return {1'b0, use2 & b2, b1};
		else
			return {1'b1, outer};
	endfunction

endpackage

[rtl/core/sbsm_in_if.sv]
// sbsm_in_if: write channel carrying one cpu write per item
// depends on sbsm_pkg for field widths
interface sbsm_in_if import sbsm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] write_addr;
	logic [DATA_W-1:0] write_data;

	modport source(output valid, write_addr, write_data, input ready);
	modport sink(input valid, write_addr, write_data, output ready);
endinterface

[rtl/core/sbsm_out_if.sv]
// sbsm_out_if: result channel carrying the mapping after each write
// depends on sbsm_pkg for field widths
interface sbsm_out_if import sbsm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] prg_slot_0;
	logic [SLOT_W-1:0] prg_slot_1;
	logic [SLOT_W-1:0] prg_slot_2;
	logic [SLOT_W-1:0] prg_slot_3;
	logic [1:0]        mirror_mode;
	logic [CHR_W-1:0]  chr_low_base;
	logic [CHR_W-1:0]  chr_high_base;
	logic [2:0]        loaded_register;

	modport source(output valid, prg_slot_0, prg_slot_1, prg_slot_2, prg_slot_3,
		mirror_mode, chr_low_base, chr_high_base, loaded_register, input ready);
	modport sink(input valid, prg_slot_0, prg_slot_1, prg_slot_2, prg_slot_3,
		mirror_mode, chr_low_base, chr_high_base, loaded_register, output ready);
endinterface

[rtl/core/sbsm_update.sv]
// sbsm_update: next mapper state for one write (serial shift, register load, apply)
// depends on sbsm_pkg
module sbsm_update import sbsm_pkg::*; (
	input  map_state_t st,
	input  map_cfg_t   cfg,
	input  logic [1:0] region,
	input  logic       reset_bit,
	input  logic       serial_bit,
	output map_state_t nxt,
	output logic [2:0] loaded
);

	always_comb begin
		logic [4:0] sb;
		logic [2:0] sc;
		logic [4:0] bits;
		logic [2:0] cnt;
		logic [4:0] c0;
		logic [4:0] v1;
		logic [4:0] v2;
		logic [4:0] v3;
		logic [4:0] b;
		logic [6:0] cl;
		logic       big;
		logic       mid;
		logic       small_cart;

		nxt = st;
		loaded = NO_LOAD;
		big = (cfg.bank_count == BIG_COUNT);
		mid = (cfg.bank_count == MID_COUNT);
		small_cart = is_small(cfg.bank_count);
		sb = (region != st.last_region) ? 5'd0 : st.shift_bits;
		sc = (region != st.last_region) ? 3'd0 : st.shift_count;
		if (sc > LAST_BIT)
			sc = 3'd0;
		bits = sb | ({4'd0, serial_bit} << sc);
		cnt = sc + 3'd1;
		c0 = st.ctrl[REG_CTRL];
		v1 = (region == REG_CHR0) ? bits : st.ctrl[REG_CHR0];
		v2 = (region == REG_CHR1) ? bits : st.ctrl[REG_CHR1];
		v3 = bits;
		b = 5'd0;
		cl = 7'd0;
		nxt.last_region = region;
		nxt.shift_bits = sb;
		nxt.shift_count = sc;

		if (reset_bit) begin
			nxt.shift_bits = 5'd0;
			nxt.shift_count = 3'd0;
		end else if (sc == LAST_BIT) begin
			nxt.shift_bits = 5'd0;
			nxt.shift_count = 3'd0;
			nxt.ctrl[region] = bits;
			loaded = {1'b0, region};
			unique case (region)
				REG_CTRL: begin
				end
				REG_CHR0: begin
					if (big) begin
						if (c0[4])
							{nxt.swap_latch, nxt.outer_base} =
								swap_step(st.swap_latch, st.outer_base, v1[4], v2[4], c0[3]);
						else
							nxt.outer_base = v1[4] ? 2'd3 : 2'd0;
					end else if (mid && !cfg.has_chr_rom) begin
						nxt.outer_base = {1'b0, v1[4]};
					end else if (c0[4]) begin
						nxt.chr_low = {v1, 2'b00};
					end else if (cfg.has_chr_rom) begin
						cl = {v1[4:1], 3'b000};
						nxt.chr_low = cl;
						nxt.chr_high = cl + 7'd4;
					end
				end
				REG_CHR1: begin
					if (big && c0[3])
						{nxt.swap_latch, nxt.outer_base} =
							swap_step(st.swap_latch, st.outer_base, v1[4], v2[4], 1'b1);
					if (c0[4])
						nxt.chr_high = {v2, 2'b00};
				end
				REG_PRG: begin
					if (c0[3]) begin
						b = {v3[3:0], 1'b0};
						if (c0[2]) begin
							nxt.slots[0] = b;
							nxt.slots[1] = b + 5'd1;
							nxt.slots[2] = hi_one(cfg.bank_count);
							nxt.slots[3] = hi_two(cfg.bank_count);
						end else if (small_cart) begin
							nxt.slots[0] = 5'd0;
							nxt.slots[1] = 5'd1;
							nxt.slots[2] = b;
							nxt.slots[3] = b + 5'd1;
						end
					end else begin
						b = {v3[3:1], 2'b00};
						nxt.slots[0] = b;
						nxt.slots[1] = b + 5'd1;
						if (small_cart) begin
							nxt.slots[2] = b + 5'd2;
							nxt.slots[3] = b + 5'd3;
						end
					end
				end
			endcase
		end else begin
			nxt.shift_bits = bits;
			nxt.shift_count = cnt;
		end
	end

endmodule

[rtl/core/serial_bank_switch_mapper_unit.sv]
// serial_bank_switch_mapper_unit: top level of the serial bank switch mapper
// depends on sbsm_pkg, sbsm_in_if, sbsm_out_if and sbsm_update
//
// channel   dir  handshake      payload
// wr_in     in   valid/ready    write_addr[15:0], write_data[7:0]
// map_out   out  valid/ready    prg_slot_0..3, mirror_mode, chr bases, loaded_register
// apb       in   psel/penable   paddr[2:0], pwdata[31:0], prdata[31:0], pready
//
// an item waits in the input register while the update logic works on it, then the
// result register loads it once the result slot is free or being drained; one item
// per cycle sustained while map_out is not stalled
// the mapper state is updated in the single cycle where an item leaves the input
// register (apb config writes win), which bounds throughput to one item per clock
// arst_n clears the valid bits and loads the power-up mapping (ctrl0 0x0C,
// slots 0, 1, 30, 31, bank count 32, chr rom present)
// a stalled result holds both stages; the input side keeps taking items while
// the input register is empty or moves on
module serial_bank_switch_mapper_unit import sbsm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	sbsm_in_if.sink           wr_in,
	sbsm_out_if.source        map_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	// config registers
	map_cfg_t   cfg_q;
	// live mapper state
	map_state_t st_q;
	map_state_t st_nxt;
	logic [2:0] loaded_nxt;

	// input register: only the address region and data bits 7 and 0 matter
	logic       valid_s1;
	logic [1:0] region_s1;
	logic       reset_bit_s1;
	logic       serial_bit_s1;

	// result register
	logic       out_valid_q;

	logic adv;
	logic fire_s1;
	logic cfg_wr;

	// result slot is free or being drained
	assign adv     = !out_valid_q || map_out.ready;
	assign fire_s1 = valid_s1 && adv;
	assign wr_in.ready = !valid_s1 || adv;
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	// register read back
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			CFG_BANK_COUNT: prdata = {{(APB_DW-COUNT_W){1'b0}}, cfg_q.bank_count};
			CFG_HAS_CHR:    prdata = {{(APB_DW-1){1'b0}}, cfg_q.has_chr_rom};
		endcase
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (wr_in.valid && wr_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_in.valid && wr_in.ready) begin
			region_s1     <= wr_in.write_addr[14:13];
			reset_bit_s1  <= wr_in.write_data[7];
			serial_bit_s1 <= wr_in.write_data[0];
		end
	end

	sbsm_update u_update (
		.st         (st_q),
		.cfg        (cfg_q),
		.region     (region_s1),
		.reset_bit  (reset_bit_s1),
		.serial_bit (serial_bit_s1),
		.nxt        (st_nxt),
		.loaded     (loaded_nxt)
	);

	// config and mapper state; a bank count write restores the start slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bank_count  <= COUNT_RESET;
			cfg_q.has_chr_rom <= 1'b1;
			st_q.shift_bits   <= 5'd0;
			st_q.shift_count  <= 3'd0;
			st_q.last_region  <= 2'd0;
			st_q.ctrl         <= {5'd0, 5'd0, 5'd0, CTRL0_RESET};
			st_q.slots        <= {hi_two(COUNT_RESET), hi_one(COUNT_RESET), 5'd1, 5'd0};
			st_q.outer_base   <= 2'd0;
			st_q.swap_latch   <= 1'b0;
			st_q.chr_low      <= 7'd0;
			st_q.chr_high     <= 7'd0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				CFG_BANK_COUNT: begin
					cfg_q.bank_count <= pwdata[COUNT_W-1:0];
					st_q.slots <= {hi_two(pwdata[COUNT_W-1:0]), hi_one(pwdata[COUNT_W-1:0]),
						5'd1, 5'd0};
					st_q.outer_base <= 2'd0;
					st_q.swap_latch <= 1'b0;
				end
				CFG_HAS_CHR: begin
					cfg_q.has_chr_rom <= pwdata[0];
				end
			endcase
		end else if (fire_s1) begin
			st_q <= st_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			map_out.prg_slot_0      <= {st_nxt.outer_base, st_nxt.slots[0]};
			map_out.prg_slot_1      <= {st_nxt.outer_base, st_nxt.slots[1]};
			map_out.prg_slot_2      <= {st_nxt.outer_base, st_nxt.slots[2]};
			map_out.prg_slot_3      <= {st_nxt.outer_base, st_nxt.slots[3]};
			map_out.mirror_mode     <= st_nxt.ctrl[REG_CTRL][1:0];
			map_out.chr_low_base    <= st_nxt.chr_low;
			map_out.chr_high_base   <= st_nxt.chr_high;
			map_out.loaded_register <= loaded_nxt;
		end
	end

	assign map_out.valid = out_valid_q;

	// serial count never passes the fifth bit
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.shift_count <= LAST_BIT)
		else $error("shift count out of range");

	// an item leaving the input register always shows up as a result
	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> out_valid_q)
		else $error("result lost");

	// a register load empties the shift register
	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && !cfg_wr && loaded_nxt != NO_LOAD) |=>
		(st_q.shift_count == 3'd0 && st_q.shift_bits == 5'd0))
		else $error("shift not cleared after load");

	// the swap latch only exists on 1024K carts
	a_swap_big: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.swap_latch |-> (cfg_q.bank_count == BIG_COUNT))
		else $error("swap latch set on small cart");

	// outer base only moves on 512K and 1024K carts
	a_outer_small: assert property (@(posedge clk) disable iff (!arst_n)
		is_small(cfg_q.bank_count) |-> (st_q.outer_base == 2'd0))
		else $error("outer base set on small cart");

endmodule

[tb/sv/serial_bank_switch_mapper_unit_tb.sv]
// serial_bank_switch_mapper_unit_tb: self-checking bench for the serial bank switch mapper
// depends on sbsm_pkg, sbsm_in_if, sbsm_out_if and serial_bank_switch_mapper_unit
// writes are mirrored into a local mapper model and every mapping result is compared
module serial_bank_switch_mapper_unit_tb;
	import sbsm_pkg::*;

	localparam int IDLE_LIMIT = 2000;   // cycles with no item moving before giving up

	// one expected mapping, in the field order of the result channel
	typedef struct packed {
		logic [3:0][SLOT_W-1:0] prg;
		logic [1:0]             mirror;
		logic [CHR_W-1:0]       chr_lo;
		logic [CHR_W-1:0]       chr_hi;
		logic [2:0]             loaded;
	} mapping_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	sbsm_in_if  wr_ch();
	sbsm_out_if map_ch();

	serial_bank_switch_mapper_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_in   (wr_ch),
		.map_out (map_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// local mapper model: cart setup, serial shifter and bank registers
	// ---------------------------------------------------------------------
	logic [7:0] cart_banks;
	logic       cart_chr_rom;
	logic [4:0] shift_acc;
	logic [2:0] shift_len;
	logic [1:0] prev_region;
	logic [4:0] ctrl_reg [4];
	logic [7:0] slot_raw [4];
	logic [1:0] outer_bank;
	logic       swap_pending;
	logic [6:0] chr_lo_bank;
	logic [6:0] chr_hi_bank;

	mapping_t pending_maps[$];   // mappings predicted for accepted writes, oldest first

	int errors = 0;
	int writes_sent = 0;
	int maps_checked = 0;
	int cart_setups = 0;
	int loads_seen [5] = '{0, 0, 0, 0, 0};
	int burst_left = 0;

	function automatic logic small_cart();
		return (cart_banks != BIG_COUNT) && (cart_banks != MID_COUNT);
	endfunction

	// last two 8K banks; small carts wrap modulo 256 below two banks
	function automatic logic [7:0] top_bank(input logic second);
		if (small_cart())
			return cart_banks - (second ? 8'd1 : 8'd2);
		return second ? {3'b000, HI_TWO_LARGE} : {3'b000, HI_ONE_LARGE};
	endfunction

	// power-up slot layout, also restored whenever the bank count is rewritten
	function automatic void reload_slots();
		slot_raw[0] = 8'd0;
		slot_raw[1] = 8'd1;
		slot_raw[2] = top_bank(1'b0);
		slot_raw[3] = top_bank(1'b1);
		outer_bank = 2'd0;
		swap_pending = 1'b0;
	endfunction

	// 1024K carts: the outer 256K base only moves on every second write
	function automatic void step_swap(input logic with_chr1);
		if (swap_pending) begin
			outer_bank = {with_chr1 & ctrl_reg[REG_CHR1][4], ctrl_reg[REG_CHR0][4]};
			swap_pending = 1'b0;
		end else begin
			swap_pending = 1'b1;
		end
	endfunction

	function automatic void apply_control(input logic [1:0] idx);
		logic       chr4k;
		logic       prg16;
		logic [4:0] v;
		logic [7:0] base;
		chr4k = ctrl_reg[REG_CTRL][4];
		prg16 = ctrl_reg[REG_CTRL][3];
		v = ctrl_reg[idx];
		case (idx)
			REG_CHR0: begin
				if (cart_banks == BIG_COUNT) begin
					if (chr4k)
						step_swap(prg16);
					else
						outer_bank = v[4] ? 2'd3 : 2'd0;
				end else if (cart_banks == MID_COUNT && !cart_chr_rom) begin
					outer_bank = {1'b0, v[4]};
				end else if (chr4k) begin
					chr_lo_bank = {v, 2'b00};
				end else if (cart_chr_rom) begin
					// 8K chr mode ignores the low bit and pairs the two halves
					chr_lo_bank = {v[4:1], 3'b000};
					chr_hi_bank = chr_lo_bank + 7'd4;
				end
			end
			REG_CHR1: begin
				if (cart_banks == BIG_COUNT && prg16)
					step_swap(1'b1);
				if (chr4k)
					chr_hi_bank = {v, 2'b00};
			end
			REG_PRG: begin
				if (prg16) begin
					base = {2'b00, v, 1'b0};
					if (ctrl_reg[REG_CTRL][2]) begin
						slot_raw[0] = base;
						slot_raw[1] = base + 8'd1;
						slot_raw[2] = top_bank(1'b0);
						slot_raw[3] = top_bank(1'b1);
					end else if (small_cart()) begin
						slot_raw[0] = 8'd0;
						slot_raw[1] = 8'd1;
						slot_raw[2] = base;
						slot_raw[3] = base + 8'd1;
					end
				end else begin
					base = {2'b00, v[4:1], 2'b00};
					slot_raw[0] = base;
					slot_raw[1] = base + 8'd1;
					if (small_cart()) begin
						slot_raw[2] = base + 8'd2;
						slot_raw[3] = base + 8'd3;
					end
				end
			end
			default: ;   // control register: modes only take effect on later loads
		endcase
	endfunction

	// advances the model by one cpu write and returns the mapping it reports
	function automatic mapping_t compute_mapping(input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data);
		mapping_t   m;
		logic [1:0] region;
		region = addr[14:13];
		m.loaded = NO_LOAD;
		if (region != prev_region) begin
			shift_acc = 5'd0;
			shift_len = 3'd0;
		end
		prev_region = region;
		if (data[7]) begin
			shift_acc = 5'd0;
			shift_len = 3'd0;
		end else begin
			if (shift_len > LAST_BIT)
				shift_len = 3'd0;
			if (data[0])
				shift_acc[shift_len] = 1'b1;
			shift_len = shift_len + 3'd1;
			if (shift_len > LAST_BIT) begin
				ctrl_reg[region] = shift_acc;
				shift_acc = 5'd0;
				shift_len = 3'd0;
				m.loaded = {1'b0, region};
				apply_control(region);
			end
		end
		for (int i = 0; i < 4; i++)
			m.prg[i] = {outer_bank, slot_raw[i][4:0]};
		m.mirror = ctrl_reg[REG_CTRL][1:0];
		m.chr_lo = chr_lo_bank;
		m.chr_hi = chr_hi_bank;
		return m;
	endfunction

	// ---------------------------------------------------------------------
	// result side: stall pattern and field-by-field check
	// ---------------------------------------------------------------------
	logic        sink_ready = 1'b0;
	logic [15:0] stall_pat = 16'hFFFF;
	logic [5:0]  stall_age = 6'd0;

	assign map_ch.ready = sink_ready;

	// the pattern rotates each cycle and is redrawn whenever the 6-bit age wraps; an all-ones
	// pattern gives stretches with no stalls, bit 0 forced bounds stalls by the pattern length
	always @(posedge clk) begin
		stall_age <= stall_age + 6'd1;
		if (stall_age == 6'd0) begin
			case ($urandom_range(0, 3))
				0: stall_pat <= 16'hFFFF;
				1: stall_pat <= 16'h5555;
				default: stall_pat <= 16'($urandom()) | 16'h0001;
			endcase
		end else begin
			stall_pat <= {stall_pat[0], stall_pat[15:1]};
		end
		sink_ready <= stall_pat[0];
	end

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		mapping_t want;
		if (arst_n && map_ch.valid && map_ch.ready) begin
			if (pending_maps.size() == 0) begin
				errors++;
				$display("%0t: mapping result with no write pending, expected none, actual loaded %0d",
					$time, map_ch.loaded_register);
			end else begin
				want = pending_maps.pop_front();
				maps_checked++;
				check_field("prg_slot_0", 8'(want.prg[0]), 8'(map_ch.prg_slot_0));
				check_field("prg_slot_1", 8'(want.prg[1]), 8'(map_ch.prg_slot_1));
				check_field("prg_slot_2", 8'(want.prg[2]), 8'(map_ch.prg_slot_2));
				check_field("prg_slot_3", 8'(want.prg[3]), 8'(map_ch.prg_slot_3));
				check_field("mirror_mode", 8'(want.mirror), 8'(map_ch.mirror_mode));
				check_field("chr_low_base", 8'(want.chr_lo), 8'(map_ch.chr_low_base));
				check_field("chr_high_base", 8'(want.chr_hi), 8'(map_ch.chr_high_base));
				check_field("loaded_register", 8'(want.loaded), 8'(map_ch.loaded_register));
			end
		end
	end

	// watchdog: any cycle in which an item moves on either channel restarts the count
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((wr_ch.valid && wr_ch.ready) || (map_ch.valid && map_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no item moved for %0d cycles, %0d mappings still pending",
				$time, IDLE_LIMIT, pending_maps.size());
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// write side
	// ---------------------------------------------------------------------

	// sends one cpu write, bursts of random length separated by random gaps;
	// valid stays high between back-to-back writes and is dropped only by gaps
	// and by drain_writes
	task automatic send_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				wr_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		wr_ch.valid <= 1'b1;
		wr_ch.write_addr <= addr;
		wr_ch.write_data <= data;
		@(posedge clk);
		while (!wr_ch.ready)
			@(posedge clk);
		// accepted at this edge: model the write in acceptance order
		pending_maps.push_back(compute_mapping(addr, data));
		loads_seen[pending_maps[$].loaded]++;
		writes_sent++;
	endtask

	// address in the given 8K region; bit 15 sometimes clear to reach below the mapper space
	function automatic logic [ADDR_W-1:0] region_addr(input logic [1:0] region);
		return {($urandom_range(0, 9) != 0), region, 13'($urandom())};
	endfunction

	// a well-formed five-write serial load, lsb first, with junk in data bits 6:1
	task automatic load_serial(input logic [1:0] region, input logic [4:0] value);
		for (int k = 0; k < 5; k++)
			send_write(region_addr(region), {1'b0, 6'($urandom()), value[k]});
	endtask

	// stop sending and wait until every predicted mapping has come back
	task automatic drain_writes();
		wr_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_maps.size() != 0)
			@(posedge clk);
		// then wait on, so that any stray result from the input or result register is caught
		repeat (6) @(posedge clk);
	endtask

	// one apb write followed by a read back of the same register
	task automatic apb_write_check(input logic idx, input logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {{(APB_DW - 8){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== {{(APB_DW - 8){1'b0}}, value}) begin
			errors++;
			$display("%0t: register %0d read back, expected %0d, actual %0d",
				$time, idx, value, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// new cart setup; only called with the pipeline drained
	task automatic setup_cart(input logic [7:0] banks, input logic chr_rom);
		apb_write_check(CFG_BANK_COUNT, banks);
		cart_banks = banks;
		reload_slots();
		apb_write_check(CFG_HAS_CHR, {7'd0, chr_rom});
		cart_chr_rom = chr_rom;
		cart_setups++;
	endtask

	// mostly well-formed loads with random content, the rest reset writes,
	// cut-off sequences and the odd full drain
	task automatic random_writes(input int count);
		int sent;
		int pick;
		int cut;
		logic [1:0] region;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			region = 2'($urandom());
			if (pick < 75) begin
				load_serial(region, 5'($urandom()));
				sent += 5;
			end else if (pick < 85) begin
				send_write(region_addr(region), {1'b1, 7'($urandom())});
				sent++;
			end else if (pick < 98) begin
				// partial shift, usually broken by the next write's region or reset bit
				cut = $urandom_range(1, 4);
				repeat (cut)
					send_write(region_addr(region), {1'b0, 7'($urandom())});
				sent += cut;
			end else begin
				drain_writes();
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------

	// power-up mapping, extremes of both fields, reset bit mid-shift, a shift
	// broken by a region change and a load from below the mapper space
	task automatic test_directed();
		send_write(16'hFFFF, 8'hFF);      // reset bit at the top address
		send_write(16'h0000, 8'h80);      // outside the mapper space, region 0
		send_write(16'h8000, 8'h01);      // control = 0x1F: 4K chr, 16K prg at 0x8000
		send_write(16'h9FFF, 8'h7F);
		send_write(16'h8001, 8'h03);
		send_write(16'h8ABC, 8'h01);
		send_write(16'h0123, 8'h41);
		load_serial(REG_PRG, 5'h1F);      // top 16K bank
		send_write(16'hA000, 8'h01);      // two bits, then the reset bit
		send_write(16'hA001, 8'h7E);
		send_write(16'hA002, 8'h80);
		send_write(16'hC000, 8'h01);      // one bit, then cleared by region change
		send_write(16'h2000, 8'h00);      // chr bank 0 from below 0x8000
		send_write(16'h3FFF, 8'h00);
		send_write(16'h2001, 8'h00);
		send_write(16'h2002, 8'h00);
		send_write(16'h2003, 8'h00);
		drain_writes();
	endtask

	// sweep of cart layouts: 1024K and 512K schemes with chr rom and ram,
	// the smallest legal count, tiny counts that wrap, odd sizes
	task automatic test_cart_layouts();
		logic [7:0] banks  [10] = '{BIG_COUNT, BIG_COUNT, MID_COUNT, MID_COUNT, 8'd2,
			8'd2, 8'd1, 8'd0, 8'd16, 8'd127};
		logic       chr_on [10] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
			1'b1, 1'b0};
		for (int i = 0; i < 10; i++) begin
			setup_cart(banks[i], chr_on[i]);
			random_writes(150);
			drain_writes();
		end
	endtask

	// unshaped writes: any address, any data, on a random layout
	task automatic test_raw_noise();
		logic [7:0] banks;
		case ($urandom_range(0, 2))
			0: banks = BIG_COUNT;
			1: banks = MID_COUNT;
			default: banks = 8'($urandom_range(2, 128));
		endcase
		setup_cart(banks, 1'($urandom()));
		repeat (300)
			send_write(16'($urandom()), 8'($urandom()));
		drain_writes();
	endtask

	initial begin
		// power-up model state
		cart_banks = COUNT_RESET;
		cart_chr_rom = 1'b1;
		shift_acc = 5'd0;
		shift_len = 3'd0;
		prev_region = 2'd0;
		ctrl_reg = '{CTRL0_RESET, 5'd0, 5'd0, 5'd0};
		chr_lo_bank = 7'd0;
		chr_hi_bank = 7'd0;
		reload_slots();

		arst_n <= 1'b0;
		wr_ch.valid <= 1'b0;
		wr_ch.write_addr <= '0;
		wr_ch.write_data <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_cart_layouts();
		test_raw_noise();

		drain_writes();
		repeat (20) @(posedge clk);
		$display("covered %0d writes and %0d checked mappings over %0d cart setups",
			writes_sent, maps_checked, cart_setups);
		$display("loads seen: control %0d, chr0 %0d, chr1 %0d, prg %0d, none %0d",
			loads_seen[0], loads_seen[1], loads_seen[2], loads_seen[3], loads_seen[4]);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
